// ===== hdl/psp_pkg.sv =====
// Shared types and constants of the planar shadow projector.
`timescale 1ns / 1ps
package psp_pkg;

  localparam int unsigned NEAR_ZERO_DEF = 16;
  localparam int unsigned QBITS = 33;

  typedef enum logic [2:0] {
    REG_DIR_X    = 3'd0,
    REG_DIR_Y    = 3'd1,
    REG_DIR_Z    = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_VANISH_X = 3'd6,
    REG_VANISH_Y = 3'd7
  } psp_reg_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } psp_pt_t;

  // Payload handed from one divider cell to the next.
  typedef struct packed {
    logic [31:0]       rem;
    logic [QBITS-1:0]  lo;
    logic [31:0]       dmag;
    logic              neg;
    logic              par;
    logic              ovf;
    psp_pt_t           pt;
  } psp_div_t;

endpackage

// ===== hdl/psp_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per request.
`timescale 1ns / 1ps
module psp_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  psp_pkg::psp_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output psp_pkg::psp_div_t data_o
);
  import psp_pkg::*;

  logic     valid_q;
  psp_div_t data_q, data_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    trial  = {data_i.rem, data_i.lo[QBITS-1]};
    diff   = trial - {1'b0, data_i.dmag};
    ge     = trial >= {1'b0, data_i.dmag};
    data_d = data_i;
    data_d.rem = ge ? diff[31:0] : trial[31:0];
    data_d.lo  = {data_i.lo[QBITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/planar_shadow_projector.sv =====
// Top level of the planar shadow projector: front end, divider chain, back end.
//
// Usage
//   Write the direction, normal and vanishing point through the cfg port while
//   no vertex is in flight. Each request on s_axis carries one vertex
//   (px, py, pz, Q16.16); each request on m_axis returns the projected vertex
//   (qx, qy, qz) and the travel along the direction, all Q16.16, saturated.
//   The pipeline runs from input request to output valid through four front
//   stages (products, sums, magnitudes, dividend), 33 divider cells giving one
//   quotient bit each, and three back stages (saturate travel, scale the
//   direction, round and add). The row of divider cells sets the latency.
//   Throughput is one vertex per cycle while m_axis_tready holds; every stage
//   holds its own valid bit. When the receiver stalls, results stay at the
//   output and the pipeline keeps filling its empty stages, so s_axis_tready
//   drops only once every stage holds a vertex.
//   Reset clears all valid bits and loads the default configuration: unit z
//   direction, unit z normal and a vanishing point at the origin.
//   A direction parallel to the plane (|n.dir| below NEAR_ZERO) gives zero
//   travel and returns the vertex unchanged.
`timescale 1ns / 1ps
module planar_shadow_projector #(
  parameter int unsigned NEAR_ZERO = psp_pkg::NEAR_ZERO_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // px, py, pz from the lowest bit up
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // qx, qy, qz, travel from the lowest bit up
);
  import psp_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic signed [15:0] nrm_x_q, nrm_y_q, nrm_z_q;
  logic signed [31:0] van_x_q, van_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= 16'sd16384;
      nrm_x_q <= '0;
      nrm_y_q <= '0;
      nrm_z_q <= 16'sd16384;
      van_x_q <= '0;
      van_y_q <= '0;
    end else if (cfg_we_i) begin
      case (psp_reg_e'(cfg_idx_i))
        REG_DIR_X:    dir_x_q <= cfg_data_i[15:0];
        REG_DIR_Y:    dir_y_q <= cfg_data_i[15:0];
        REG_DIR_Z:    dir_z_q <= cfg_data_i[15:0];
        REG_NORMAL_X: nrm_x_q <= cfg_data_i[15:0];
        REG_NORMAL_Y: nrm_y_q <= cfg_data_i[15:0];
        REG_NORMAL_Z: nrm_z_q <= cfg_data_i[15:0];
        REG_VANISH_X: van_x_q <= cfg_data_i;
        REG_VANISH_Y: van_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- helpers ----------------
  function automatic logic signed [31:0] sat32(input logic signed [35:0] s);
    if (s > 36'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (s < -36'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = s[31:0];
    end
  endfunction

  // Shift a 30-fraction-bit step right by 14, ties away from zero, add p.
  function automatic logic signed [31:0] step_add(input logic signed [31:0] p,
                                                  input logic signed [47:0] v);
    logic [47:0]        mag;
    logic [47:0]        rnd;
    logic signed [35:0] stp;
    logic signed [35:0] sum;
    mag = v[47] ? 48'(-v) : 48'(v);
    rnd = (mag + 48'd8192) >> 14;
    stp = v[47] ? -$signed({2'b00, rnd[33:0]}) : $signed({2'b00, rnd[33:0]});
    sum = 36'(p) + stp;
    step_add = sat32(sum);
  endfunction

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic [QBITS:0] cv;
  logic [QBITS:0] cr;
  psp_div_t       cd [QBITS+1];

  assign en7 = !v7_q || m_axis_tready;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || cr[0];
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign cr[QBITS] = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= cv[QBITS];
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // ---------------- stage 1: products ----------------
  psp_pt_t            pin;
  psp_pt_t            pt1_q, pt2_q, pt3_q, pt5_q, pt6_q;
  logic signed [32:0] dx_d, dy_d;
  logic signed [48:0] na_q, nb_q;
  logic signed [47:0] nc_q;
  logic signed [31:0] de_q, df_q, dg_q;

  assign pin.px = s_axis_tdata[31:0];
  assign pin.py = s_axis_tdata[63:32];
  assign pin.pz = s_axis_tdata[95:64];
  assign dx_d = 33'(pin.px) - 33'(van_x_q);
  assign dy_d = 33'(pin.py) - 33'(van_y_q);

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      pt1_q <= pin;
      na_q  <= 49'(nrm_x_q) * 49'(dx_d);
      nb_q  <= 49'(nrm_y_q) * 49'(dy_d);
      nc_q  <= 48'(nrm_z_q) * 48'(pin.pz);
      de_q  <= 32'(nrm_x_q) * 32'(dir_x_q);
      df_q  <= 32'(nrm_y_q) * 32'(dir_y_q);
      dg_q  <= 32'(nrm_z_q) * 32'(dir_z_q);
    end
  end

  // ---------------- stage 2: sums ----------------
  logic signed [50:0] num_q;
  logic signed [32:0] den_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pt2_q <= pt1_q;
      num_q <= 51'(na_q) + 51'(nb_q) + 51'(nc_q);
      den_q <= 33'(de_q) + 33'(df_q) + 33'(dg_q);
    end
  end

  // ---------------- stage 3: magnitudes and signs ----------------
  logic [50:0] nabs_d;
  logic [32:0] dabs_d;
  logic [49:0] nmag_q;
  logic [31:0] dmag_q;
  logic        neg3_q, par3_q;

  assign nabs_d = num_q[50] ? 51'(-num_q) : 51'(num_q);
  assign dabs_d = den_q[32] ? 33'(-den_q) : 33'(den_q);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      pt3_q  <= pt2_q;
      nmag_q <= nabs_d[49:0];
      dmag_q <= dabs_d[31:0];
      // Travel is negative when num and denom share a sign.
      neg3_q <= (num_q != '0) && (num_q[50] == den_q[32]);
      par3_q <= dabs_d[31:0] < 32'(NEAR_ZERO);
    end
  end

  // ---------------- stage 4: dividend, overflow test ----------------
  logic [64:0] dvd_d;
  logic        ovf_d;
  psp_div_t    c0_q, c0_d;

  assign dvd_d = {1'b0, nmag_q, 14'b0} + 65'(dmag_q[31:1]);
  assign ovf_d = dvd_d[64:33] >= dmag_q;

  always_comb begin
    c0_d.rem  = (ovf_d || par3_q) ? 32'd0 : dvd_d[64:33];
    c0_d.lo   = dvd_d[QBITS-1:0];
    c0_d.dmag = dmag_q;
    c0_d.neg  = neg3_q;
    c0_d.par  = par3_q;
    c0_d.ovf  = ovf_d;
    c0_d.pt   = pt3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      c0_q <= c0_d;
    end
  end

  assign cv[0] = v4_q;
  assign cd[0] = c0_q;

  // ---------------- divider chain ----------------
  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    psp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .data_o  (cd[i+1])
    );
  end

  // ---------------- stage 5: saturate travel ----------------
  psp_div_t           fin;
  logic [QBITS-1:0]   qm;
  logic signed [31:0] dist_d, dist5_q, dist6_q;

  assign fin = cd[QBITS];
  assign qm  = fin.lo;

  always_comb begin
    if (fin.par) begin
      dist_d = '0;
    end else if (fin.neg) begin
      dist_d = (fin.ovf || qm > 33'h080000000) ? 32'sh80000000 : 32'(-qm);
    end else begin
      dist_d = (fin.ovf || qm > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : qm[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && cv[QBITS]) begin
      pt5_q   <= fin.pt;
      dist5_q <= dist_d;
    end
  end

  // ---------------- stage 6: scale the direction ----------------
  logic signed [47:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      pt6_q   <= pt5_q;
      dist6_q <= dist5_q;
      sx_q    <= 48'(dir_x_q) * 48'(dist5_q);
      sy_q    <= 48'(dir_y_q) * 48'(dist5_q);
      sz_q    <= 48'(dir_z_q) * 48'(dist5_q);
    end
  end

  // ---------------- stage 7: round, add, output register ----------------
  logic signed [31:0] qx_q, qy_q, qz_q, trv_q;

  always_ff @(posedge clk_i) begin
    if (en7 && v6_q) begin
      qx_q  <= step_add(pt6_q.px, sx_q);
      qy_q  <= step_add(pt6_q.py, sy_q);
      qz_q  <= step_add(pt6_q.pz, sz_q);
      trv_q <= dist6_q;
    end
  end

  assign m_axis_tvalid = v7_q;
  assign m_axis_tdata  = {trv_q, qz_q, qy_q, qx_q};

`ifndef SYNTH
  // A parallel direction gives zero travel.
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[QBITS] && en5 && fin.par) |=> (dist5_q == 32'sd0))
    else $error("parallel vertex with nonzero travel");

  // The remainder leaving the last cell stays below the divisor.
  a_rem_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[QBITS] && !fin.par && !fin.ovf) |-> (fin.rem < fin.dmag))
    else $error("divider remainder not reduced");

  // Same-signed num and denom never give positive travel.
  a_neg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[QBITS] && en5 && !fin.par && fin.neg) |=> (dist5_q <= 32'sd0))
    else $error("travel sign wrong");
`endif

endmodule
